### hdl/first_fit_heap_allocator_assert.svh
// assertion macros for the heap allocator checker
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define FFHA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define FFHA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;

	localparam int HEAP_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 8;
	localparam int REQ_W            = 13;
	localparam int ADDR_W           = 12;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FAIL    = 3'd1,
		ST_NOINIT  = 3'd2,
		ST_BADADDR = 3'd3,
		ST_DOUBLE  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_INIT,
		DP_START,
		DP_RD_CUR,
		DP_STEP,
		DP_RD_BLK,
		DP_CAP_BLK,
		DP_SPLIT_REM,
		DP_ALLOC_LINK,
		DP_ALLOC_CUR,
		DP_FREE_WR,
		DP_LINK_PREV,
		DP_DONE
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t st;
	} dp_cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic ready;
		logic addr_bad;
		logic cur_nil;
		logic cur_gt_blk;
		logic cur_eq_blk;
		logic fits;
		logic split;
		logic prev_nil;
		logic merge_prev;
		logic out_free;
	} dp_flags_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_INIT,
		S_ASTART,
		S_ACHK,
		S_AEVAL,
		S_ALINK,
		S_ACUR,
		S_FCAP,
		S_FCHK,
		S_FEVAL,
		S_FNXT,
		S_FLINK,
		S_DONE
	} state_t;

endpackage

### hdl/ffha_ctrl.sv
`timescale 1ns / 1ps
module ffha_ctrl
	import ffha_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  dp_flags_t flags,
	output dp_cmd_t   cmd
);

	state_t  state_q, state_d;
	status_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd.op  = DP_NOP;
		cmd.st  = st_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = DP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (flags.is_alloc) begin
					state_d = flags.ready ? S_ASTART : S_INIT;
				end else if (!flags.ready) begin
					st_d    = ST_NOINIT;
					state_d = S_DONE;
				end else if (flags.addr_bad) begin
					st_d    = ST_BADADDR;
					state_d = S_DONE;
				end else begin
					cmd.op  = DP_RD_BLK;
					state_d = S_FCAP;
				end
			end
			S_INIT: begin
				cmd.op  = DP_INIT;
				state_d = S_ASTART;
			end
			S_ASTART: begin
				cmd.op  = DP_START;
				state_d = S_ACHK;
			end
			S_ACHK: begin
				if (flags.cur_nil) begin
					st_d    = ST_FAIL;
					state_d = S_DONE;
				end else begin
					cmd.op  = DP_RD_CUR;
					state_d = S_AEVAL;
				end
			end
			S_AEVAL: begin
				if (!flags.fits) begin
					cmd.op  = DP_STEP;
					state_d = S_ACHK;
				end else if (flags.split) begin
					cmd.op  = DP_SPLIT_REM;
					state_d = S_ALINK;
				end else begin
					cmd.op  = DP_ALLOC_LINK;
					state_d = S_ACUR;
				end
			end
			S_ALINK: begin
				cmd.op  = DP_ALLOC_LINK;
				state_d = S_ACUR;
			end
			S_ACUR: begin
				cmd.op  = DP_ALLOC_CUR;
				st_d    = ST_OK;
				state_d = S_DONE;
			end
			S_FCAP: begin
				cmd.op  = DP_CAP_BLK;
				state_d = S_FCHK;
			end
			S_FCHK: begin
				if (flags.cur_nil || flags.cur_gt_blk) begin
					// fetch the following block for a possible merge
					if (!flags.cur_nil)
						cmd.op = DP_RD_CUR;
					state_d = S_FNXT;
				end else if (flags.cur_eq_blk) begin
					st_d    = ST_DOUBLE;
					state_d = S_DONE;
				end else begin
					cmd.op  = DP_RD_CUR;
					state_d = S_FEVAL;
				end
			end
			S_FEVAL: begin
				cmd.op  = DP_STEP;
				state_d = S_FCHK;
			end
			S_FNXT: begin
				cmd.op  = DP_FREE_WR;
				state_d = S_FLINK;
			end
			S_FLINK: begin
				if (!flags.prev_nil && !flags.merge_prev)
					cmd.op = DP_LINK_PREV;
				st_d    = ST_OK;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (flags.out_free) begin
					cmd.op  = DP_DONE;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### hdl/ffha_dp.sv
`timescale 1ns / 1ps
module ffha_dp
	import ffha_pkg::*;
#(
	parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_flags_t         flags,
	input  logic              in_op,
	input  logic [REQ_W-1:0]  in_req,
	input  logic [ADDR_W-1:0] in_addr,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [ADDR_W-1:0] out_addr,
	output logic [2:0]        out_status
);

	localparam int AW = $clog2(HEAP_BYTES);
	localparam int SW = AW + 1;
	localparam int XW = ((SW > REQ_W) ? SW : REQ_W) + 2;
	localparam int EW = 1 + AW + SW;

	logic [EW-1:0] mem [HEAP_BYTES];
	logic [EW-1:0] rd_q;

	logic              op_q;
	logic [REQ_W-1:0]  req_q;
	logic [ADDR_W-1:0] addr_q;
	logic [AW-1:0]     cur_q, prev_q, head_q;
	logic              cur_nil_q, prev_nil_q, head_nil_q, ready_q;
	logic [SW-1:0]     psize_q, bsize_q;
	logic              ovalid_q;
	logic [ADDR_W-1:0] oaddr_q;
	logic [2:0]        ostatus_q;

	logic          rd_nil;
	logic [AW-1:0] rd_next;
	logic [SW-1:0] rd_size;
	assign rd_nil  = rd_q[EW-1];
	assign rd_next = rd_q[SW +: AW];
	assign rd_size = rd_q[SW-1:0];

	logic [31:0]   blk_w;
	logic [AW-1:0] blk;
	logic [XW-1:0] hb_x, req_x, size_x, rem_x;
	logic          fits, split, merge_prev, merge_nxt, addr_bad;
	logic [AW-1:0] base;
	logic [XW-1:0] s1, s2;
	logic [AW-1:0] tgt;
	logic          tgt_nil;

	assign blk_w    = 32'(addr_q) - 32'(HEADER_BYTES);
	assign blk      = blk_w[AW-1:0];
	assign addr_bad = (32'(addr_q) >= 32'(HEAP_BYTES)) || (32'(addr_q) < 32'(HEADER_BYTES));
	assign hb_x     = XW'(HEADER_BYTES);
	assign req_x    = XW'(req_q);
	assign size_x   = XW'(rd_size);
	assign rem_x    = XW'(cur_q) + hb_x + req_x;
	assign fits     = size_x >= req_x;
	assign split    = ((size_x - req_x) > hb_x) && (rem_x < XW'(HEAP_BYTES));

	// target of the predecessor link after an allocation
	assign tgt      = split ? rem_x[AW-1:0] : rd_next;
	assign tgt_nil  = split ? 1'b0 : rd_nil;

	// coalescing with the lower and upper neighbours
	assign merge_prev = !prev_nil_q && ((XW'(prev_q) + hb_x + XW'(psize_q)) == XW'(blk));
	assign base       = merge_prev ? prev_q : blk;
	assign s1         = merge_prev ? (XW'(psize_q) + hb_x + XW'(bsize_q)) : XW'(bsize_q);
	assign merge_nxt  = !cur_nil_q && ((XW'(base) + hb_x + s1) == XW'(cur_q));
	assign s2         = merge_nxt ? (s1 + hb_x + size_x) : s1;

	always_comb begin
		flags.is_alloc   = !op_q;
		flags.ready      = ready_q;
		flags.addr_bad   = addr_bad;
		flags.cur_nil    = cur_nil_q;
		flags.cur_gt_blk = cur_q > blk;
		flags.cur_eq_blk = cur_q == blk;
		flags.fits       = fits;
		flags.split      = split;
		flags.prev_nil   = prev_nil_q;
		flags.merge_prev = merge_prev;
		flags.out_free   = !ovalid_q || !out_stall;
	end

	logic          we, re;
	logic [AW-1:0] wa, ra;
	logic [EW-1:0] wd;

	always_comb begin
		we = 1'b0;
		re = 1'b0;
		wa = cur_q;
		ra = cur_q;
		wd = rd_q;
		unique case (cmd.op)
			DP_INIT: begin
				we = 1'b1;
				wa = '0;
				wd = {1'b1, {AW{1'b0}}, SW'(HEAP_BYTES - HEADER_BYTES)};
			end
			DP_RD_CUR: re = 1'b1;
			DP_RD_BLK: begin
				re = 1'b1;
				ra = blk;
			end
			DP_SPLIT_REM: begin
				we = 1'b1;
				wa = rem_x[AW-1:0];
				wd = {rd_nil, rd_next, SW'(size_x - hb_x - req_x)};
			end
			DP_ALLOC_LINK: begin
				we = !prev_nil_q;
				wa = prev_q;
				wd = {tgt_nil, tgt, psize_q};
			end
			DP_ALLOC_CUR: begin
				we = 1'b1;
				wd = {1'b1, {AW{1'b0}}, split ? SW'(req_q) : rd_size};
			end
			DP_FREE_WR: begin
				we = 1'b1;
				wa = base;
				wd = merge_nxt ? {rd_nil, rd_next, s2[SW-1:0]}
				               : {cur_nil_q, cur_q, s2[SW-1:0]};
			end
			DP_LINK_PREV: begin
				we = 1'b1;
				wa = prev_q;
				wd = {1'b0, blk, psize_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (re)
			rd_q <= mem[ra];
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_LOAD: begin
				op_q   <= in_op;
				req_q  <= in_req;
				addr_q <= in_addr;
			end
			DP_STEP: begin
				prev_q  <= cur_q;
				psize_q <= rd_size;
				cur_q   <= rd_next;
			end
			DP_START: cur_q <= head_q;
			DP_CAP_BLK: begin
				bsize_q <= rd_size;
				cur_q   <= head_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			head_nil_q <= 1'b1;
			ready_q    <= 1'b0;
			cur_nil_q  <= 1'b1;
			prev_nil_q <= 1'b1;
			ovalid_q   <= 1'b0;
			oaddr_q    <= '0;
			ostatus_q  <= ST_OK;
		end else begin
			if (cmd.op == DP_DONE)
				ovalid_q <= 1'b1;
			else if (!out_stall)
				ovalid_q <= 1'b0;
			unique case (cmd.op)
				DP_INIT: begin
					head_q     <= '0;
					head_nil_q <= 1'b0;
					ready_q    <= 1'b1;
				end
				DP_START, DP_CAP_BLK: begin
					cur_nil_q  <= head_nil_q;
					prev_nil_q <= 1'b1;
				end
				DP_STEP: begin
					cur_nil_q  <= rd_nil;
					prev_nil_q <= 1'b0;
				end
				DP_ALLOC_LINK: begin
					if (prev_nil_q) begin
						head_q     <= tgt;
						head_nil_q <= tgt_nil;
					end
				end
				DP_FREE_WR: begin
					if (prev_nil_q) begin
						head_q     <= blk;
						head_nil_q <= 1'b0;
					end
				end
				DP_DONE: begin
					ostatus_q <= cmd.st;
					oaddr_q   <= (!op_q && cmd.st == ST_OK)
					             ? ADDR_W'(32'(cur_q) + 32'(HEADER_BYTES)) : '0;
				end
				default: ;
			endcase
		end
	end

	assign out_valid  = ovalid_q;
	assign out_addr   = oaddr_q;
	assign out_status = ostatus_q;

endmodule

### hdl/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// allocate: time grows with the blocks walked, with an extra step when a block is split and on the first
// free: time grows with the free blocks below the word's block; early errors end before the walk
// one request at a time; the next word can be taken in the cycle after the result is loaded
// result sits in an output register, so the next word is taken while it waits
// reset clears the free list head, the heap-ready flag and the output valid
// header memory has no reset; it is set up by the first allocate
module first_fit_heap_allocator
	import ffha_pkg::*;
#(
	parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [REQ_W-1:0]  alloc_size,
	input  logic [ADDR_W-1:0] block_address,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ADDR_W-1:0] payload_address,
	output logic [2:0]        status
);

	dp_cmd_t   cmd;
	dp_flags_t flags;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.flags    (flags),
		.cmd      (cmd)
	);

	ffha_dp #(
		.HEAP_BYTES   (HEAP_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.flags      (flags),
		.in_op      (op),
		.in_req     (alloc_size),
		.in_addr    (block_address),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_addr   (payload_address),
		.out_status (status)
	);

endmodule

### hdl/ffha_checker.sv
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_assert.svh"
module ffha_checker
	import ffha_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [ADDR_W-1:0] payload_address,
	input logic [2:0]        status
);

	`FFHA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(payload_address))
	`FFHA_ASSERT_NOW(a_addr_zero, out_valid && status != ST_OK, payload_address == '0)
	`FFHA_ASSERT_NOW(a_status_code, out_valid, status <= ST_DOUBLE)
	`FFHA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.payload_address (payload_address),
	.status          (status)
);
